// ----- src/pkhp_pkg.sv -----
// Package: constants, types and config codes for the pattern key hash probe.
package pkhp_pkg;

  localparam int unsigned TableDepthDef = 65536;
  localparam int unsigned KeyDigitsDef  = 5;
  localparam int unsigned MaxResultsDef = 64;

  localparam int unsigned BinFields = 5;
  localparam logic [31:0] HashMult  = 32'd2654435761;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CfgTableSize  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBinFactor  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgProbeLimit = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StKey,
    StHashA,
    StHashB,
    StMod,
    StProbeAddr,
    StProbeRead,
    StProbeCheck,
    StEmit
  } state_e;

  // request from the control FSM to the 64-by-N modulo unit
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
  } mod_req_t;

endpackage

// ----- src/pkhp_mod.sv -----
// Restoring modulo unit: one dividend bit per cycle, 64-bit dividend.
module pkhp_mod #(
  parameter int unsigned DivW = 17
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pkhp_pkg::mod_req_t      req_i,
  input  logic [DivW-1:0]         divisor_i,
  output logic                    done_o,
  output logic [DivW-1:0]         rem_o
);
  import pkhp_pkg::*;

  logic [63:0]     dvd_q, dvd_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [6:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DivW:0]   trial;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[63]};
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below divisor, so trial fits DivW+1 bits
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = DivW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[DivW-1:0];
      end
      dvd_d = {dvd_q[62:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- src/pattern_key_hash_probe_core.sv -----
// Top level: pattern table memory, key hash and quadratic probe sequencer.
//
// Usage: pulse start with kind_i and the payload while busy is low.
// A write beat (kind 0) stores four star indices at slot_address_i into a
// one-port synchronous table. busy stays high while the table is written,
// and the beat yields no result.
// A lookup beat (kind 1) builds the key polynomial over KEY_DIGITS digits
// (one digit per cycle, Horner order). It then multiplies by the golden hash
// constant in two 32x32 halves and reduces modulo the table size in a
// bit-serial unit before the first probe.
// The probe offset p*p mod size is kept incrementally: (p+1)^2 = p^2 + 2p + 1,
// with compare-and-subtract steps, so no further divider is needed.
// Each probe takes three states: address, table read, check.
// A walk stopped by probe_limit or by the table size ends in one more state,
// StEmit, which issues the final beat.
// Each result is a one-cycle beat on res_valid_o, registered the cycle after
// it is decided. A hit is held until the next probe shows whether it is last.
// The final beat appears in the first cycle with busy low.
// The receiver cannot stall; results are never held back.
// Reset returns the config registers to 65536 / 50 / 64 and idles the FSM.
// The table itself is not cleared: write every slot before probing it.
module pattern_key_hash_probe_core #(
  parameter int unsigned TABLE_DEPTH = pkhp_pkg::TableDepthDef,
  parameter int unsigned KEY_DIGITS  = pkhp_pkg::KeyDigitsDef,
  parameter int unsigned MAX_RESULTS = pkhp_pkg::MaxResultsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [pkhp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pkhp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          kind_i,
  input  logic [15:0]                   slot_address_i,
  input  logic [15:0]                   star_first_i,
  input  logic [15:0]                   star_second_i,
  input  logic [15:0]                   star_third_i,
  input  logic [15:0]                   star_fourth_i,
  input  logic [5:0]                    bin_zero_i,
  input  logic [5:0]                    bin_one_i,
  input  logic [5:0]                    bin_two_i,
  input  logic [5:0]                    bin_three_i,
  input  logic [5:0]                    bin_four_i,
  output logic                          res_valid_o,
  output logic [15:0]                   slot_index_o,
  output logic                          found_o,
  output logic                          last_o,
  output logic                          truncated_o
);
  import pkhp_pkg::*;

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned SizeW = AddrW + 1;
  localparam int unsigned DigW  = (KEY_DIGITS > 1) ? $clog2(KEY_DIGITS) : 1;
  localparam int unsigned ResW  = $clog2(MAX_RESULTS + 1);

  // config
  logic [16:0] tbl_size_q;
  logic [6:0]  bin_factor_q;
  logic [6:0]  probe_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_size_q    <= 17'd65536;
      bin_factor_q  <= 7'd50;
      probe_limit_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTableSize:  tbl_size_q    <= cfg_data_i;
        CfgBinFactor:  bin_factor_q  <= cfg_data_i[6:0];
        CfgProbeLimit: probe_limit_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // effective size and limit
  logic [SizeW-1:0] size_eff;
  logic [ResW-1:0]  limit_eff;
  always_comb begin
    if (tbl_size_q == 17'd0) begin
      size_eff = SizeW'(1);
    end else if (32'(tbl_size_q) > TABLE_DEPTH) begin
      size_eff = SizeW'(TABLE_DEPTH);
    end else begin
      size_eff = SizeW'(tbl_size_q);
    end
    if (probe_limit_q == 7'd0) begin
      limit_eff = ResW'(1);
    end else if (32'(probe_limit_q) > MAX_RESULTS) begin
      limit_eff = ResW'(MAX_RESULTS);
    end else begin
      limit_eff = ResW'(probe_limit_q);
    end
  end

  // pattern table memory
  logic [63:0]      mem [TABLE_DEPTH];
  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [63:0]      mem_wdata;
  logic [63:0]      mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_addr];
  end

  // FSM and datapath registers
  state_e           state_q, state_d;
  logic [5:0]       bins_q [BinFields];
  logic [DigW-1:0]  dig_q, dig_d;
  logic [63:0]      acc_q, acc_d;
  logic [63:0]      plo_q, plo_d;
  logic [63:0]      phi_q, phi_d;
  logic [SizeW-1:0] home_q, home_d;
  logic [SizeW-1:0] sq_q, sq_d;     // p*p mod size
  logic [SizeW-1:0] inc_q, inc_d;   // (2p+1) mod size
  logic [SizeW-1:0] slot_q, slot_d;
  logic [SizeW-1:0] p_q, p_d;       // probe count, up to size
  logic [ResW-1:0]  cnt_q, cnt_d;
  logic             wr_q, wr_d;
  logic [15:0]      waddr_q;
  logic [63:0]      wdata_q;
  logic             pend_q, pend_d;
  logic [15:0]      pend_slot_q, pend_slot_d;
  logic             fin_t_q, fin_t_d;
  logic             res_valid_d, found_d, last_d, trunc_d;
  logic [15:0]      res_slot_d;
  logic             out_v_q, out_f_q, out_l_q, out_t_q;
  logic [15:0]      out_s_q;
  logic             accept;
  logic             hit, stop_lim, stop_size;
  mod_req_t         mod_req;
  logic             mod_done;
  logic [SizeW-1:0] mod_rem;

  pkhp_mod #(.DivW(SizeW)) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mod_req),
    .divisor_i (size_eff),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  logic [5:0]       cur_digit;
  logic [SizeW:0]   sum_slot;
  logic [SizeW:0]   sum_sq;
  logic [SizeW+1:0] sum_inc;

  assign busy   = (state_q != StIdle) || wr_q;
  assign accept = start && !busy;

  always_comb begin
    if (32'(dig_q) < BinFields) begin
      cur_digit = bins_q[3'(dig_q)];
    end else begin
      cur_digit = '0;
    end
    sum_slot  = {1'b0, home_q} + {1'b0, sq_q};
    sum_sq    = {1'b0, sq_q} + {1'b0, inc_q};
    sum_inc   = {2'b0, inc_q} + (SizeW+2)'(2);
    hit       = mem_rdata_q != 64'd0;
    stop_lim  = (cnt_q + ResW'(1)) >= limit_eff;
    stop_size = p_q >= size_eff;
  end

  always_comb begin
    state_d     = state_q;
    dig_d       = dig_q;
    acc_d       = acc_q;
    plo_d       = plo_q;
    phi_d       = phi_q;
    home_d      = home_q;
    sq_d        = sq_q;
    inc_d       = inc_q;
    slot_d      = slot_q;
    p_d         = p_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    fin_t_d     = fin_t_q;
    wr_d        = 1'b0;
    mod_req     = '0;
    res_valid_d = 1'b0;
    found_d     = 1'b0;
    last_d      = 1'b0;
    trunc_d     = 1'b0;
    res_slot_d  = '0;
    mem_we      = wr_q && (32'(waddr_q) < TABLE_DEPTH);
    mem_addr    = wr_q ? AddrW'(waddr_q) : AddrW'(slot_q);
    mem_wdata   = wdata_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (!kind_i) begin
            wr_d = 1'b1;
          end else begin
            dig_d   = DigW'(KEY_DIGITS - 1);
            acc_d   = '0;
            state_d = StKey;
          end
        end
      end
      StKey: begin
        // Horner: acc = acc * factor + digit, highest digit first
        acc_d = acc_q * 64'(bin_factor_q) + 64'(cur_digit);
        if (dig_q == '0) begin
          state_d = StHashA;
        end else begin
          dig_d = dig_q - DigW'(1);
        end
      end
      StHashA: begin
        plo_d   = 64'(acc_q[31:0]) * 64'(HashMult);
        phi_d   = 64'(acc_q[63:32]) * 64'(HashMult);
        state_d = StHashB;
      end
      StHashB: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = plo_q + {phi_q[31:0], 32'd0};
        state_d          = StMod;
      end
      StMod: begin
        if (mod_done) begin
          home_d  = mod_rem;
          sq_d    = '0;
          inc_d   = (size_eff == SizeW'(1)) ? '0 : SizeW'(1);
          p_d     = '0;
          cnt_d   = '0;
          pend_d  = 1'b0;
          state_d = StProbeAddr;
        end
      end
      StProbeAddr: begin
        slot_d  = (sum_slot >= {1'b0, size_eff}) ? SizeW'(sum_slot - {1'b0, size_eff})
                                                  : SizeW'(sum_slot);
        state_d = StProbeRead;
      end
      StProbeRead: begin
        // address holds slot_q this cycle; data lands next cycle
        sq_d    = (sum_sq >= {1'b0, size_eff}) ? SizeW'(sum_sq - {1'b0, size_eff})
                                              : SizeW'(sum_sq);
        inc_d   = (sum_inc >= {1'b0, size_eff, 1'b0}) ?
                    SizeW'(sum_inc - {1'b0, size_eff, 1'b0}) :
                  (sum_inc >= {2'b0, size_eff}) ?
                    SizeW'(sum_inc - {2'b0, size_eff}) : SizeW'(sum_inc);
        p_d     = p_q + SizeW'(1);
        state_d = StProbeCheck;
      end
      StProbeCheck: begin
        if (hit) begin
          // another hit follows the held one, so the held one is not last
          if (pend_q) begin
            res_valid_d = 1'b1;
            found_d     = 1'b1;
            res_slot_d  = pend_slot_q;
          end
          pend_d      = 1'b1;
          pend_slot_d = 16'(slot_q);
          cnt_d       = cnt_q + ResW'(1);
          if (stop_lim || stop_size) begin
            fin_t_d = stop_lim && (p_q < size_eff);
            state_d = StEmit;
          end else begin
            state_d = StProbeAddr;
          end
        end else begin
          // empty slot ends the walk: flush the held hit or report a miss
          res_valid_d = 1'b1;
          last_d      = 1'b1;
          found_d     = pend_q;
          res_slot_d  = pend_q ? pend_slot_q : 16'd0;
          pend_d      = 1'b0;
          state_d     = StIdle;
        end
      end
      StEmit: begin
        res_valid_d = 1'b1;
        found_d     = 1'b1;
        last_d      = 1'b1;
        trunc_d     = fin_t_q;
        res_slot_d  = pend_slot_q;
        pend_d      = 1'b0;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wr_q    <= 1'b0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
      out_f_q <= 1'b0;
      out_l_q <= 1'b0;
      out_t_q <= 1'b0;
      out_s_q <= '0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      out_v_q <= res_valid_d;
      out_f_q <= found_d;
      out_l_q <= last_d;
      out_t_q <= trunc_d;
      out_s_q <= res_slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      waddr_q <= slot_address_i;
      wdata_q <= {star_fourth_i, star_third_i, star_second_i, star_first_i};
      bins_q[0] <= bin_zero_i;
      bins_q[1] <= bin_one_i;
      bins_q[2] <= bin_two_i;
      bins_q[3] <= bin_three_i;
      bins_q[4] <= bin_four_i;
    end
    dig_q       <= dig_d;
    acc_q       <= acc_d;
    plo_q       <= plo_d;
    phi_q       <= phi_d;
    home_q      <= home_d;
    sq_q        <= sq_d;
    inc_q       <= inc_d;
    slot_q      <= slot_d;
    p_q         <= p_d;
    pend_slot_q <= pend_slot_d;
    fin_t_q     <= fin_t_d;
  end

  assign res_valid_o  = out_v_q;
  assign slot_index_o = out_s_q;
  assign found_o      = out_f_q;
  assign last_o       = out_l_q;
  assign truncated_o  = out_t_q;

`ifndef SYNTHESIS
  a_last_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_l_q |=> !out_v_q || !out_l_q)
    else $error("two final beats in a row");
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_t_q |-> out_v_q && out_l_q && out_f_q)
    else $error("truncated outside final hit");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_f_q |-> out_s_q == 16'd0 && out_l_q)
    else $error("miss beat carries slot");
`endif

endmodule
